// ===== hdl/adn_pkg.sv =====
// adn_pkg: shared widths, constants and types for the adpcm nibble decoder
// no dependencies; used by the interfaces, the modules and the checker
`timescale 1ns / 1ps

package adn_pkg;

   // channel payload widths
   localparam int BYTE_W   = 8;
   localparam int SAMPLE_W = 16;
   localparam int NIB_W    = 4;

   // predictor table and configuration port
   localparam int PRED_COUNT = 8;
   localparam int PRED_W     = 3;
   localparam int COEF_W     = 16;
   localparam int PAIR_W     = 2 * COEF_W;
   localparam int CSR_IDX_W  = 8;
   localparam int SCALE_W    = 4;
   localparam int POS_W      = 3;

   // header byte fields
   localparam int HDR_PRED_LSB  = 4;
   localparam int HDR_SCALE_LSB = 0;

   // sample arithmetic
   localparam int SCALE_BASE = 11;
   localparam int OUT_SHIFT  = 5;
   localparam int PROD_W     = 2 * COEF_W;
   localparam int STEP_W     = 31;
   localparam int SUM_W      = 34;
   localparam int ACC_W      = SUM_W + OUT_SHIFT + 1;
   localparam int SHAMT_W    = 5;
   localparam int RND_BIT    = 16;

   localparam logic [15:0]          RND_HALF = 16'h8000;
   localparam logic signed [ACC_W-1:0] RND_UNIT = ACC_W'(64'sh10000);
   localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'(64'sh7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] SAT_MIN  = ACC_W'(-64'sh8000_0000);
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

   // frame position that expects a header
   localparam logic [POS_W-1:0] POS_HEADER = '0;

   // configuration write bundle from the top level to the coefficient bank
   typedef struct packed {
      logic                  we;
      logic [CSR_IDX_W-1:0]  index;
      logic [PAIR_W-1:0]     data;
   } csr_write_type;

endpackage

// ===== hdl/adn_req_if.sv =====
// adn_req_if: request channel carrying one compressed byte and a restart flag
// depends on adn_pkg
`timescale 1ns / 1ps

interface adn_req_if;
   logic                        valid;
   logic                        ready;
   logic [adn_pkg::BYTE_W-1:0]  data_byte;
   logic                        restart;

   modport source (output valid, output data_byte, output restart, input ready);
   modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

// ===== hdl/adn_rsp_if.sv =====
// adn_rsp_if: result channel carrying one decoded sample and its last flag
// depends on adn_pkg
`timescale 1ns / 1ps

interface adn_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [adn_pkg::SAMPLE_W-1:0]  pcm_sample;
   logic                                 last;

   modport source (output valid, output pcm_sample, output last, input ready);
   modport sink   (input valid, input pcm_sample, input last, output ready);
endinterface

// ===== hdl/dsp_adpcm_nibble_decoder.sv =====
// dsp_adpcm_nibble_decoder: top level of the 4-bit adpcm frame decoder
// depends on adn_pkg, adn_req_if, adn_rsp_if, adn_coef_regs, adn_sample_calc
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+------------------------------
//   req     | in  | valid / ready      | data_byte[7:0], restart
//   rsp     | out | valid / ready      | pcm_sample[15:0] signed, last
//   csr     | in  | csr_we (no wait)   | csr_index[7:0], csr_wdata[31:0]
//
// a header byte gives no sample; a data byte is held in one input register
// and gives two samples, one sample per cycle while the output register is
// free or being drained, set by the history loop through the sample datapath.
// each sample goes from the held byte through the sample datapath into the
// output register. a stalled result holds in the output register, and
// the next request is still taken once the held byte has its last sample
// computed. reset is synchronous and clears frame position, histories,
// coefficients and all valid flags.
`timescale 1ns / 1ps

module dsp_adpcm_nibble_decoder (
   input  logic                              clock,
   input  logic                              reset,
   adn_req_if.sink                           req,
   adn_rsp_if.source                         rsp,
   input  logic                              csr_we,
   input  logic [adn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [adn_pkg::PAIR_W-1:0]        csr_wdata
);

   // frame and predictor state
   logic [adn_pkg::POS_W-1:0]           pos_ff, pos_in;
   logic [adn_pkg::PRED_W-1:0]          pred_ff, pred_in;
   logic [adn_pkg::SCALE_W-1:0]         scale_ff, scale_in;
   logic signed [adn_pkg::SAMPLE_W-1:0] hist_new_ff, hist_new_in;
   logic signed [adn_pkg::SAMPLE_W-1:0] hist_old_ff, hist_old_in;

   // held data byte
   logic                                pend_ff, pend_in;
   logic                                phase_ff, phase_in;
   logic [adn_pkg::BYTE_W-1:0]          byte_ff, byte_in;

   // output register
   logic                                out_valid_ff, out_valid_in;
   logic signed [adn_pkg::SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic                                out_last_ff, out_last_in;

   adn_pkg::csr_write_type              csr_wr;
   logic [adn_pkg::PAIR_W-1:0]          pair;
   logic [adn_pkg::NIB_W-1:0]           nibble;
   logic signed [adn_pkg::SAMPLE_W-1:0] sample;
   logic                                fire;
   logic                                take;
   logic                                is_header;

   assign csr_wr = '{we: csr_we, index: csr_index, data: csr_wdata};

   adn_coef_regs u_coef (
      .clock    (clock),
      .reset    (reset),
      .csr_wr   (csr_wr),
      .rd_index (pred_ff),
      .rd_pair  (pair)
   );

   // high nibble first
   assign nibble = phase_ff ? byte_ff[adn_pkg::NIB_W-1:0]
                            : byte_ff[adn_pkg::BYTE_W-1:adn_pkg::NIB_W];

   adn_sample_calc u_calc (
      .pair     (pair),
      .hist_new (hist_new_ff),
      .hist_old (hist_old_ff),
      .nibble   (nibble),
      .scale    (scale_ff),
      .sample   (sample)
   );

   // handshake
   assign fire      = pend_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !pend_ff || (phase_ff && fire);
   assign take      = req.valid && req.ready;
   assign is_header = req.restart || (pos_ff == adn_pkg::POS_HEADER);

   // next state
   always_comb begin
      pos_in        = pos_ff;
      pred_in       = pred_ff;
      scale_in      = scale_ff;
      hist_new_in   = hist_new_ff;
      hist_old_in   = hist_old_ff;
      pend_in       = pend_ff;
      phase_in      = phase_ff;
      byte_in       = byte_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_sample_in = out_sample_ff;
      out_last_in   = out_last_ff;

      // one sample out of the held byte
      if (fire) begin
         hist_old_in   = hist_new_ff;
         hist_new_in   = sample;
         out_valid_in  = 1'b1;
         out_sample_in = sample;
         out_last_in   = phase_ff;
         phase_in      = !phase_ff;
         pend_in       = !phase_ff;
      end

      // new request: header updates predictor, data byte is held
      if (take) begin
         if (req.restart) begin
            hist_new_in = '0;
            hist_old_in = '0;
         end
         if (is_header) begin
            pred_in  = req.data_byte[adn_pkg::HDR_PRED_LSB +: adn_pkg::PRED_W];
            scale_in = req.data_byte[adn_pkg::HDR_SCALE_LSB +: adn_pkg::SCALE_W];
            pos_in   = adn_pkg::POS_W'(1);
         end else begin
            byte_in  = req.data_byte;
            pend_in  = 1'b1;
            phase_in = 1'b0;
            pos_in   = pos_ff + adn_pkg::POS_W'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= adn_pkg::POS_HEADER;
         pred_ff      <= '0;
         scale_ff     <= '0;
         hist_new_ff  <= '0;
         hist_old_ff  <= '0;
         pend_ff      <= 1'b0;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         pred_ff      <= pred_in;
         scale_ff     <= scale_in;
         hist_new_ff  <= hist_new_in;
         hist_old_ff  <= hist_old_in;
         pend_ff      <= pend_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      out_sample_ff <= out_sample_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.pcm_sample = out_sample_ff;
   assign rsp.last       = out_last_ff;

endmodule

// ===== hdl/adn_coef_regs.sv =====
// adn_coef_regs: bank of eight predictor coefficient pairs with one read port
// depends on adn_pkg
`timescale 1ns / 1ps

module adn_coef_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  adn_pkg::csr_write_type          csr_wr,
   input  logic [adn_pkg::PRED_W-1:0]      rd_index,
   output logic [adn_pkg::PAIR_W-1:0]      rd_pair
);

   logic [adn_pkg::PAIR_W-1:0] pair_ff [adn_pkg::PRED_COUNT];
   logic                       wr_hit;

   // indexes beyond the bank are dropped
   assign wr_hit = csr_wr.we &&
                   (csr_wr.index < adn_pkg::CSR_IDX_W'(adn_pkg::PRED_COUNT));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < adn_pkg::PRED_COUNT; i++) begin
            pair_ff[i] <= '0;
         end
      end else if (wr_hit) begin
         pair_ff[csr_wr.index[adn_pkg::PRED_W-1:0]] <= csr_wr.data;
      end
   end

   assign rd_pair = pair_ff[rd_index];

endmodule

// ===== hdl/adn_sample_calc.sv =====
// adn_sample_calc: one adpcm sample from coefficient pair, histories and nibble
// depends on adn_pkg; pure combinational datapath
`timescale 1ns / 1ps

module adn_sample_calc (
   input  logic [adn_pkg::PAIR_W-1:0]          pair,
   input  logic signed [adn_pkg::SAMPLE_W-1:0] hist_new,
   input  logic signed [adn_pkg::SAMPLE_W-1:0] hist_old,
   input  logic [adn_pkg::NIB_W-1:0]           nibble,
   input  logic [adn_pkg::SCALE_W-1:0]         scale,
   output logic signed [adn_pkg::SAMPLE_W-1:0] sample
);

   logic signed [adn_pkg::COEF_W-1:0]  c0;
   logic signed [adn_pkg::COEF_W-1:0]  c1;
   logic signed [adn_pkg::PROD_W-1:0]  prod_new;
   logic signed [adn_pkg::PROD_W-1:0]  prod_old;
   logic [adn_pkg::SHAMT_W-1:0]        shamt;
   logic signed [adn_pkg::STEP_W-1:0]  step;
   logic signed [adn_pkg::SUM_W-1:0]   sum;
   logic signed [adn_pkg::ACC_W-1:0]   acc;
   logic signed [adn_pkg::ACC_W-1:0]   acc_rnd;
   logic                               rnd_up;

   // two predictor products
   assign c0       = signed'(pair[adn_pkg::COEF_W-1:0]);
   assign c1       = signed'(pair[adn_pkg::PAIR_W-1:adn_pkg::COEF_W]);
   assign prod_new = c0 * hist_new;
   assign prod_old = c1 * hist_old;

   // scaled residual
   assign shamt = adn_pkg::SHAMT_W'(scale) + adn_pkg::SHAMT_W'(adn_pkg::SCALE_BASE);
   assign step  = adn_pkg::STEP_W'(signed'(nibble)) <<< shamt;

   // prediction plus residual, then the fixed left shift
   assign sum = adn_pkg::SUM_W'(prod_new) + adn_pkg::SUM_W'(prod_old)
              + adn_pkg::SUM_W'(step);
   assign acc = {sum[adn_pkg::SUM_W-1], sum, adn_pkg::OUT_SHIFT'(0)};

   // round half to even at the output bit
   assign rnd_up = (acc[15:0] > adn_pkg::RND_HALF) ||
                   ((acc[15:0] == adn_pkg::RND_HALF) && acc[adn_pkg::RND_BIT]);
   assign acc_rnd = rnd_up ? (acc + adn_pkg::RND_UNIT) : acc;

   // saturate to 32 bits and keep the upper half
   always_comb begin
      if (acc_rnd > adn_pkg::SAT_MAX) begin
         sample = adn_pkg::SAMPLE_MAX;
      end else if (acc_rnd < adn_pkg::SAT_MIN) begin
         sample = adn_pkg::SAMPLE_MIN;
      end else begin
         sample = signed'(acc_rnd[31:16]);
      end
   end

endmodule

// ===== hdl/adn_checker.sv =====
// adn_checker: port-level checks on the adpcm nibble decoder, bound to the top
// depends on adn_pkg and dsp_adpcm_nibble_decoder
`timescale 1ns / 1ps

module adn_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_ready,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [adn_pkg::SAMPLE_W-1:0]      rsp_pcm_sample,
   input  logic                              rsp_last
);

   // stalled result keeps valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pcm_sample) && $stable(rsp_last))
      else $error("rsp payload changed while stalled");

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a first sample taken is followed at once by the second sample
   a_pair_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_last)
      else $error("second sample of a byte not delivered next cycle");

   // taking the first sample frees the request side
   a_pair_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |-> req_ready)
      else $error("request side blocked while last sample is computed");

endmodule

bind dsp_adpcm_nibble_decoder adn_checker u_adn_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_pcm_sample (rsp.pcm_sample),
   .rsp_last       (rsp.last)
);

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for the adpcm nibble decoder, a directed table then
// random frames under several coefficient sets; depends on adn_pkg, adn_req_if,
// adn_rsp_if and dsp_adpcm_nibble_decoder
`timescale 1ns / 1ps

module tb_top;
   import adn_pkg::*;

   localparam int CLK_HALF        = 5;
   localparam int STALL_LIMIT     = 2000;
   localparam int LONG_HOLD       = 120;
   localparam int SETTLE_CYCLES   = 4;
   localparam int TAIL_CYCLES     = 8;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 140;
   localparam int ZERO_COEF_ROWS  = 13;
   localparam int DIRECTED_ROWS   = 25;
   localparam int SHOWN_FAULTS    = 10;
   localparam int CSR_TOP_INDEX   = (1 << CSR_IDX_W) - 1;

   localparam longint PCM_ROUND_STEP = 64'sh1_0000;
   localparam longint PCM_ACC_MAX    = 64'sh7FFF_FFFF;
   localparam longint PCM_ACC_MIN    = -64'sh8000_0000;

   typedef enum int {COEF_DIRECTED, COEF_ZERO, COEF_TYPICAL, COEF_WILD, COEF_EXTREME,
                     COEF_MIXED} coef_style_type;
   typedef enum int {DRAIN_FULL, DRAIN_HALF, DRAIN_MOSTLY, DRAIN_SPARSE} drain_mode_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] pcm_sample;
      logic                       last;
   } pcm_result_type;

   typedef struct packed {
      logic [BYTE_W-1:0]          data_byte;
      logic                       restart;
      logic                       typed;
      logic signed [SAMPLE_W-1:0] first_pcm;
      logic signed [SAMPLE_W-1:0] second_pcm;
   } stim_row_type;

   // first rows run on the zero coefficients left by reset, so each sample is
   // just the nibble shifted by the scale and saturated
   localparam stim_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      '{8'h00, 1'b0, 1'b0, 16'sd0, 16'sd0},          // header: predictor 0, scale 0
      '{8'h7F, 1'b0, 1'b1, 16'sd7, -16'sd1},
      '{8'h80, 1'b0, 1'b1, -16'sd8, 16'sd0},
      '{8'h08, 1'b0, 1'b1, 16'sd0, -16'sd8},
      '{8'h11, 1'b0, 1'b1, 16'sd1, 16'sd1},
      '{8'h00, 1'b0, 1'b1, 16'sd0, 16'sd0},
      '{8'hF7, 1'b0, 1'b1, -16'sd1, 16'sd7},
      '{8'h88, 1'b0, 1'b1, -16'sd8, -16'sd8},        // seventh data byte, frame wraps
      '{8'hFF, 1'b0, 1'b0, 16'sd0, 16'sd0},          // header, bit 7 ignored, scale 15
      '{8'h78, 1'b0, 1'b1, 16'sh7FFF, -16'sh8000},   // both saturate
      '{8'h8E, 1'b1, 1'b0, 16'sd0, 16'sd0},          // restart mid-frame, taken as header
      '{8'h1F, 1'b0, 1'b1, 16'sd16384, -16'sd16384},
      '{8'h27, 1'b0, 1'b1, 16'sh7FFF, 16'sh7FFF},
      // predicted rows, run on the directed coefficient set
      '{8'h00, 1'b1, 1'b0, 16'sd0, 16'sd0},
      '{8'h7F, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h7F, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h88, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h81, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h1C, 1'b1, 1'b0, 16'sd0, 16'sd0},
      '{8'h77, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h88, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h5B, 1'b1, 1'b0, 16'sd0, 16'sd0},
      '{8'h12, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'hEF, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h3C, 1'b0, 1'b0, 16'sd0, 16'sd0}
   };

   // largest weights, most negative weights, unity integrator and small ones
   localparam logic [PAIR_W-1:0] DIRECTED_PAIRS [PRED_COUNT] = '{
      32'h7FFF_7FFF, 32'h8000_8000, 32'h7FFF_8000, 32'h8000_7FFF,
      32'hF800_0800, 32'h0000_0800, 32'hFFFF_FFFF, 32'h0001_0001
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [PAIR_W-1:0]    csr_wdata;

   adn_req_if req_ch ();
   adn_rsp_if rsp_ch ();

   dsp_adpcm_nibble_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // decoder state as the checker sees it
   logic [PAIR_W-1:0]          coef_bank [PRED_COUNT];
   logic [POS_W-1:0]           frame_pos;
   logic [PRED_W-1:0]          cur_pred;
   logic [SCALE_W-1:0]         cur_scale;
   logic signed [SAMPLE_W-1:0] hist_new;
   logic signed [SAMPLE_W-1:0] hist_old;

   pcm_result_type expected_pcm_q [$];
   int  fault_count  = 0;
   int  stall_cycles = 0;
   int  burst_left   = 0;
   bit  stall_request = 1'b0;

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // one decoded sample, history shifts afterwards
   function automatic logic signed [SAMPLE_W-1:0] predict_sample(input logic [NIB_W-1:0] nib);
      logic [PAIR_W-1:0]          pair;
      longint                     w_new, w_old, nib_val, acc;
      logic [63:0]                acc_bits;
      logic signed [SAMPLE_W-1:0] pcm;
      pair    = coef_bank[cur_pred];
      w_new   = $signed(pair[COEF_W-1:0]);
      w_old   = $signed(pair[PAIR_W-1:COEF_W]);
      nib_val = $signed(nib);
      acc = w_old * hist_old + w_new * hist_new;
      acc = acc + nib_val * (longint'(1) << (cur_scale + SCALE_BASE));
      acc = acc * (longint'(1) << OUT_SHIFT);
      // round half to even at bit 16
      acc_bits = acc;
      if (acc_bits[15:0] > 16'h8000 || (acc_bits[15:0] == 16'h8000 && acc_bits[16]))
         acc = acc + PCM_ROUND_STEP;
      if (acc > PCM_ACC_MAX)
         acc = PCM_ACC_MAX;
      else if (acc < PCM_ACC_MIN)
         acc = PCM_ACC_MIN;
      acc_bits = acc;
      pcm      = acc_bits[31:16];
      hist_old = hist_new;
      hist_new = pcm;
      return pcm;
   endfunction

   // one request: header updates predictor and scale, data byte gives two samples
   function automatic int predict_request(input logic [BYTE_W-1:0] data_byte,
                                          input logic restart,
                                          output logic signed [SAMPLE_W-1:0] first_pcm,
                                          output logic signed [SAMPLE_W-1:0] second_pcm);
      int n_samples;
      n_samples  = 0;
      first_pcm  = '0;
      second_pcm = '0;
      if (restart) begin
         hist_new  = '0;
         hist_old  = '0;
         frame_pos = POS_HEADER;
      end
      if (frame_pos == POS_HEADER) begin
         cur_pred  = data_byte[HDR_PRED_LSB +: PRED_W];
         cur_scale = data_byte[HDR_SCALE_LSB +: SCALE_W];
         frame_pos = POS_HEADER + 1'b1;
      end else begin
         first_pcm  = predict_sample(data_byte[7:4]);
         second_pcm = predict_sample(data_byte[3:0]);
         frame_pos  = frame_pos + 1'b1;
         n_samples  = 2;
      end
      return n_samples;
   endfunction

   function automatic logic [COEF_W-1:0] extreme_coef();
      case ($urandom_range(0, 3))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'hFFFF;
         default: return 16'h0000;
      endcase
   endfunction

   function automatic logic [PAIR_W-1:0] pick_pair(input coef_style_type style);
      logic [COEF_W-1:0] c0, c1;
      case (style)
         COEF_ZERO: return '0;
         COEF_TYPICAL: begin
            c0 = COEF_W'(int'($urandom_range(0, 8191)) - 4096);
            c1 = COEF_W'(int'($urandom_range(0, 4095)) - 2048);
            return {c1, c0};
         end
         COEF_WILD: return $urandom;
         COEF_EXTREME: return {extreme_coef(), extreme_coef()};
         default: return pick_pair(coef_style_type'($urandom_range(COEF_TYPICAL,
                                                                   COEF_EXTREME)));
      endcase
   endfunction

   function automatic void note_fault(input string msg);
      fault_count++;
      if (fault_count <= SHOWN_FAULTS)
         $display("%s", msg);
   endfunction

   task automatic write_csr(input int idx, input logic [PAIR_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = CSR_IDX_W'(idx);
      csr_wdata = value;
      @(posedge clock);
      if (idx < PRED_COUNT)
         coef_bank[idx] = value;
   endtask

   // every register, then one write past the table that must be ignored
   task automatic program_coefs(input coef_style_type style);
      for (int i = 0; i < PRED_COUNT; i++)
         write_csr(i, (style == COEF_DIRECTED) ? DIRECTED_PAIRS[i] : pick_pair(style));
      if (style == COEF_DIRECTED)
         write_csr(CSR_TOP_INDEX, '1);
      else
         write_csr($urandom_range(PRED_COUNT, CSR_TOP_INDEX), $urandom);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // hold the sender until every sample is back and a header has settled
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (expected_pcm_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // offer one request in a burst pattern, record its samples when taken
   task automatic offer(input logic [BYTE_W-1:0] data_byte, input logic restart,
                        input logic typed, input logic signed [SAMPLE_W-1:0] typed_first,
                        input logic signed [SAMPLE_W-1:0] typed_second);
      int                         gap, n_samples;
      logic signed [SAMPLE_W-1:0] first_pcm, second_pcm;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_ch.valid     = 1'b0;
            req_ch.data_byte = BYTE_W'($urandom);
            req_ch.restart   = 1'($urandom);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid     = 1'b1;
      req_ch.data_byte = data_byte;
      req_ch.restart   = restart;
      do @(posedge clock); while (!req_ch.ready);
      n_samples = predict_request(data_byte, restart, first_pcm, second_pcm);
      if (n_samples == 2) begin
         if (typed) begin
            first_pcm  = typed_first;
            second_pcm = typed_second;
         end
         expected_pcm_q.push_back('{pcm_sample: first_pcm, last: 1'b0});
         expected_pcm_q.push_back('{pcm_sample: second_pcm, last: 1'b1});
      end
   endtask

   // a header and its data bytes; now and then the frame is cut short
   task automatic send_frame(input logic restart, output bit cut_short, inout int sent);
      logic [BYTE_W-1:0] header;
      int                n_data;
      header[7]   = 1'($urandom);
      header[6:4] = 3'($urandom);
      header[3:0] = 4'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 8));
      n_data      = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : 7;
      cut_short   = (n_data != 7);
      offer(header, restart, 1'b0, '0, '0);
      sent++;
      repeat (n_data) begin
         offer(BYTE_W'($urandom), 1'b0, 1'b0, '0, '0);
         sent++;
      end
   endtask

   // check each sample against the oldest expectation
   always @(posedge clock) begin
      pcm_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_pcm_q.size() == 0) begin
            note_fault($sformatf("unexpected sample %0d last %0b",
                                 rsp_ch.pcm_sample, rsp_ch.last));
         end else begin
            want = expected_pcm_q.pop_front();
            if (rsp_ch.pcm_sample !== want.pcm_sample)
               note_fault($sformatf("pcm_sample mismatch: expected %0d got %0d",
                                    want.pcm_sample, rsp_ch.pcm_sample));
            if (rsp_ch.last !== want.last)
               note_fault($sformatf("last mismatch: expected %0b got %0b",
                                    want.last, rsp_ch.last));
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("dsp_adpcm_nibble_decoder verification failed");
            $finish;
         end
      end
   end

   // result side back-pressure, segments of differing density plus one long hold
   initial begin
      drain_mode_type mode;
      int             seg_len;
      rsp_ch.ready = 1'b0;
      forever begin
         mode    = drain_mode_type'($urandom_range(DRAIN_FULL, DRAIN_SPARSE));
         seg_len = $urandom_range(8, 64);
         repeat (seg_len) begin
            @(negedge clock);
            if (stall_request) begin
               rsp_ch.ready = 1'b0;
               repeat (LONG_HOLD - 1) @(negedge clock);
               stall_request = 1'b0;
            end else begin
               case (mode)
                  DRAIN_FULL:   rsp_ch.ready = 1'b1;
                  DRAIN_HALF:   rsp_ch.ready = 1'($urandom_range(0, 1));
                  DRAIN_MOSTLY: rsp_ch.ready = ($urandom_range(0, 4) != 0);
                  default:      rsp_ch.ready = ($urandom_range(0, 3) == 0);
               endcase
            end
         end
      end
   end

   // stimulus: directed table, then random frames under changing coefficients
   initial begin
      coef_style_type phase_style [RANDOM_PHASES];
      int             sent;
      bit             cut_short, stalled, paused;
      phase_style = '{COEF_TYPICAL, COEF_EXTREME, COEF_WILD, COEF_MIXED, COEF_ZERO,
                      COEF_TYPICAL};
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      req_ch.restart   = 1'b0;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      for (int i = 0; i < PRED_COUNT; i++)
         coef_bank[i] = '0;
      frame_pos = POS_HEADER;
      cur_pred  = '0;
      cur_scale = '0;
      hist_new  = '0;
      hist_old  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (r == ZERO_COEF_ROWS) begin
            wait_drained();
            program_coefs(COEF_DIRECTED);
         end
         offer(DIRECTED_TABLE[r].data_byte, DIRECTED_TABLE[r].restart, DIRECTED_TABLE[r].typed,
               DIRECTED_TABLE[r].first_pcm, DIRECTED_TABLE[r].second_pcm);
      end

      stalled = 1'b0;
      paused  = 1'b0;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         program_coefs(phase_style[p]);
         sent      = 0;
         cut_short = 1'b1;
         while (sent < ITEMS_PER_PHASE) begin
            // long result hold while requests keep coming
            if (p == 2 && sent >= 40 && !stalled) begin
               stall_request = 1'b1;
               stalled       = 1'b1;
            end
            // sender waits for every outstanding sample
            if (p == 3 && sent >= 70 && !paused) begin
               wait_drained();
               paused = 1'b1;
            end
            send_frame(cut_short || ($urandom_range(0, 3) == 0), cut_short, sent);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("dsp_adpcm_nibble_decoder verification clean");
      else
         $display("dsp_adpcm_nibble_decoder verification failed");
      $finish;
   end

endmodule
